[hdl/lbt_pkg.sv]
// Shared constants and types for the line buffer tokenizer.
// Depends on nothing. Imported by lbt_front, lbt_back, the top level and the testbench.
package lbt_pkg;

	localparam int BUF_DEPTH   = 32;
	localparam int ADDR_W      = $clog2(BUF_DEPTH);
	localparam int PTR_W       = ADDR_W + 1;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [ADDR_W-1:0] FILL_LIMIT = ADDR_W'(BUF_DEPTH - 1);

	localparam logic [7:0] NL_BYTE = 8'h0A;
	localparam logic [7:0] SP_BYTE = 8'h20;

	localparam logic [1:0] CMD_BEGIN = 2'd0;
	localparam logic [1:0] CMD_CHAR  = 2'd1;
	localparam logic [1:0] CMD_TOKEN = 2'd2;

	typedef enum logic [1:0] {
		OP_BEGIN,
		OP_CHAR,
		OP_TOKEN
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       is_nl;
		logic [7:0] ch;
	} work_item_t;

	typedef struct packed {
		logic       valid;
		work_item_t item;
	} work_head_t;

	typedef struct packed {
		logic [7:0] token_char;
		logic       token_found;
		logic       last;
		logic       overflow_line;
	} result_t;

endpackage

[hdl/lbt_ifs.sv]
// Valid/ready channel interfaces of the line buffer tokenizer.
// Standalone; the request channel and the result channel.
interface lbt_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] rx_char;

	modport source (output valid, command, rx_char, input ready);
	modport sink   (input valid, command, rx_char, output ready);
endinterface

interface lbt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] token_char;
	logic       token_found;
	logic       last;
	logic       overflow_line;

	modport source (output valid, token_char, token_found, last, overflow_line, input ready);
	modport sink   (input valid, token_char, token_found, last, overflow_line, output ready);
endinterface

[hdl/lbt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; no reset, contents undefined until written.
module lbt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/lbt_front.sv]
// Front end: accepts requests, decodes the command and queues work items.
// Depends on lbt_pkg and lbt_in_if.
module lbt_front
	import lbt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	lbt_in_if.sink      in_ch,
	input  logic        pop,
	output work_head_t  head
);

	localparam int QIDX_W = $clog2(QUEUE_DEPTH);

	work_item_t          slot_q [QUEUE_DEPTH];
	logic [QIDX_W-1:0]   wr_idx_q;
	logic [QIDX_W-1:0]   rd_idx_q;
	logic [QIDX_W:0]     count_q;
	work_item_t          item_d;
	logic                keep;
	logic                push;

	assign in_ch.ready = (count_q != (QIDX_W + 1)'(QUEUE_DEPTH));

	always_comb begin
		item_d.ch    = in_ch.rx_char;
		item_d.is_nl = (in_ch.rx_char == NL_BYTE);
		item_d.op    = OP_BEGIN;
		keep         = 1'b1;
		case (in_ch.command)
			CMD_BEGIN: item_d.op = OP_BEGIN;
			CMD_CHAR:  item_d.op = OP_CHAR;
			CMD_TOKEN: item_d.op = OP_TOKEN;
			default:   keep = 1'b0;
		endcase
	end

	// unused command codes are accepted and dropped here
	assign push = in_ch.valid && in_ch.ready && keep;

	assign head.valid = (count_q != '0);
	assign head.item  = slot_q[rd_idx_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_idx_q] <= item_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_idx_q <= (wr_idx_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_idx_q + QIDX_W'(1);
			end
			if (pop) begin
				rd_idx_q <= (rd_idx_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_idx_q + QIDX_W'(1);
			end
			count_q <= count_q + (QIDX_W + 1)'(push) - (QIDX_W + 1)'(pop);
		end
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("queue popped while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QIDX_W + 1)'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule

[hdl/lbt_back.sv]
// Back end: line store, character append, token scan and result register.
// Depends on lbt_pkg, lbt_out_if and lbt_ram.
module lbt_back
	import lbt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  work_head_t  head,
	output logic        pop,
	lbt_out_if.source   out_ch
);

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_NL_ZERO = 7'b0000010,
		ST_SKIP_RD = 7'b0000100,
		ST_SKIP_EV = 7'b0001000,
		ST_TOK_RD  = 7'b0010000,
		ST_TOK_EV  = 7'b0100000,
		ST_FIN     = 7'b1000000
	} state_t;

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] fill_q, fill_d;
	logic [PTR_W-1:0]  scan_right_q, scan_right_d;
	logic [PTR_W-1:0]  ptr_q, ptr_d;
	logic              ovf_q, ovf_d;
	logic              done_q, done_d;
	logic              any_q, any_d;
	logic              zseen_q, zseen_d;
	logic              pend_v_q, pend_v_d;
	logic [7:0]        pend_q, pend_d;
	logic              out_valid_q;
	result_t           out_q;

	logic              we, re;
	logic [ADDR_W-1:0] waddr;
	logic [7:0]        wdata;
	logic [7:0]        rd_data;
	logic              push;
	result_t           push_res;
	logic              out_free;
	logic              ptr_lt_fill;
	logic              is_delim;
	logic              ovf_line;
	logic [PTR_W-1:0]  fill_ext;

	lbt_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (ptr_q[ADDR_W-1:0]),
		.rdata (rd_data)
	);

	assign out_free    = !out_valid_q || out_ch.ready;
	assign fill_ext    = {1'b0, fill_q};
	assign ptr_lt_fill = (ptr_q < fill_ext);
	assign is_delim    = (rd_data == SP_BYTE) || (rd_data == NL_BYTE);
	assign ovf_line    = done_q && ovf_q;

	always_comb begin
		state_d      = state_q;
		fill_d       = fill_q;
		scan_right_d = scan_right_q;
		ptr_d        = ptr_q;
		ovf_d        = ovf_q;
		done_d       = done_q;
		any_d        = any_q;
		zseen_d      = zseen_q;
		pend_v_d     = pend_v_q;
		pend_d       = pend_q;
		pop          = 1'b0;
		we           = 1'b0;
		waddr        = fill_q;
		wdata        = 8'h00;
		re           = 1'b0;
		push         = 1'b0;
		push_res     = '{token_char: 8'h00, token_found: 1'b0, last: 1'b1,
			overflow_line: ovf_line};
		case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					case (head.item.op)
						OP_BEGIN: begin
							pop = 1'b1;
							if (done_q) begin
								ovf_d        = 1'b0;
								done_d       = 1'b0;
								fill_d       = '0;
								scan_right_d = '0;
							end
						end
						OP_CHAR: begin
							pop = 1'b1;
							if (!ovf_q) begin
								if (fill_q < FILL_LIMIT) begin
									we     = 1'b1;
									wdata  = head.item.ch;
									fill_d = fill_q + ADDR_W'(1);
								end else begin
									ovf_d  = 1'b1;
									fill_d = '0;
								end
							end
							if (head.item.is_nl) begin
								state_d = ST_NL_ZERO;
							end
						end
						OP_TOKEN: begin
							if (!done_q) begin
								if (out_free) begin
									pop  = 1'b1;
									push = 1'b1;
								end
							end else begin
								pop      = 1'b1;
								ptr_d    = (scan_right_q >= fill_ext) ? fill_ext : scan_right_q;
								any_d    = 1'b0;
								zseen_d  = 1'b0;
								pend_v_d = 1'b0;
								state_d  = ST_SKIP_RD;
							end
						end
						default: pop = 1'b1;
					endcase
				end
			end
			ST_NL_ZERO: begin
				// terminator just past the stored bytes
				we      = 1'b1;
				done_d  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_SKIP_RD: begin
				if (ptr_lt_fill) begin
					re      = 1'b1;
					state_d = ST_SKIP_EV;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_SKIP_EV: begin
				if (rd_data == SP_BYTE) begin
					ptr_d   = ptr_q + PTR_W'(1);
					state_d = ST_SKIP_RD;
				end else begin
					state_d = ST_TOK_EV;
				end
			end
			ST_TOK_RD: begin
				if (ptr_lt_fill) begin
					re      = 1'b1;
					state_d = ST_TOK_EV;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_TOK_EV: begin
				if (is_delim) begin
					we      = 1'b1;
					waddr   = ptr_q[ADDR_W-1:0];
					state_d = ST_FIN;
				end else if ((rd_data != 8'h00) && !zseen_q && pend_v_q && !out_free) begin
					state_d = ST_TOK_EV;
				end else begin
					any_d = 1'b1;
					if (rd_data == 8'h00) begin
						zseen_d = 1'b1;
					end else if (!zseen_q) begin
						// previous byte is not the last one: send it now
						if (pend_v_q) begin
							push     = 1'b1;
							push_res = '{token_char: pend_q, token_found: 1'b1, last: 1'b0,
								overflow_line: ovf_line};
						end
						pend_d   = rd_data;
						pend_v_d = 1'b1;
					end
					ptr_d   = ptr_q + PTR_W'(1);
					state_d = ST_TOK_RD;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					push         = 1'b1;
					scan_right_d = ptr_q + PTR_W'(1);
					state_d      = ST_IDLE;
					if (any_q) begin
						push_res = '{token_char: pend_v_q ? pend_q : 8'h00, token_found: 1'b1,
							last: 1'b1, overflow_line: ovf_line};
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fill_q       <= '0;
			scan_right_q <= '0;
			ptr_q        <= '0;
			ovf_q        <= 1'b0;
			done_q       <= 1'b0;
			any_q        <= 1'b0;
			zseen_q      <= 1'b0;
			pend_v_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			fill_q       <= fill_d;
			scan_right_q <= scan_right_d;
			ptr_q        <= ptr_d;
			ovf_q        <= ovf_d;
			done_q       <= done_d;
			any_q        <= any_d;
			zseen_q      <= zseen_d;
			pend_v_q     <= pend_v_d;
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_q <= pend_d;
		if (push) begin
			out_q <= push_res;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.token_char    = out_q.token_char;
	assign out_ch.token_found   = out_q.token_found;
	assign out_ch.last          = out_q.last;
	assign out_ch.overflow_line = out_q.overflow_line;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_LIMIT)
		else $error("fill count past buffer limit");

	a_scan_needs_line: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SKIP_RD || state_q == ST_SKIP_EV || state_q == ST_TOK_RD ||
		 state_q == ST_TOK_EV || state_q == ST_FIN) |-> done_q)
		else $error("token scan without completed line");

	a_eval_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TOK_EV || state_q == ST_SKIP_EV) |-> ptr_lt_fill)
		else $error("scan evaluates byte beyond fill count");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result register overwritten");

	a_notfound_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.token_found) |-> (out_q.last && out_q.token_char == 8'h00))
		else $error("malformed not-found result");

endmodule

[hdl/line_buffer_tokenizer_top.sv]
// Line buffer tokenizer, top level.
// Depends on lbt_pkg, lbt_ifs, lbt_front and lbt_back.
//
// in_ch carries requests: command 0 begins a read pass (clears the line if it
// was completed), 1 appends rx_char to the line buffer, 2 asks for the next
// space-separated token. Command 3 is accepted and ignored.
// out_ch carries results: one per token byte with last on the final byte, or a
// single not-found result. overflow_line flags a completed line that overflowed.
// Requests enter a two-entry queue; in_ch.ready drops only while it is full.
// A newline character also passes a second state that writes the terminator.
// A token request before the line is complete gives a not-found result once the
// result register is free. Otherwise the request is decoded, each byte walked
// takes a store read and then an evaluate, the first token byte is evaluated
// a second time and a closing state sends the final result. A token byte is
// sent on the cycle after the next byte is evaluated and the final one in the
// closing state. A stalled receiver holds the result register and the scan
// waits on it; the queue keeps accepting until full.
// After reset the line is empty and not completed; the store needs no clearing.
module line_buffer_tokenizer_top
	import lbt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	lbt_in_if.sink     in_ch,
	lbt_out_if.source  out_ch
);

	work_head_t head;
	logic       pop;

	lbt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.pop    (pop),
		.head   (head)
	);

	lbt_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

[test/tb.sv]
// Testbench for line_buffer_tokenizer_top: directed lines, then random command lines and noise.
// Predicts every token result in a scoreboard class and checks the result channel against it.
// Depends on hdl/lbt_pkg.sv, hdl/lbt_ifs.sv and hdl/line_buffer_tokenizer_top.sv.
module tb
	import lbt_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int RANDOM_REQUESTS = 360;

	class lbt_scoreboard;
		logic [7:0]  line_bytes [BUF_DEPTH];
		int unsigned fill;
		int unsigned scan_pos;
		bit          ovf;
		bit          done;
		result_t     pending_results [$];
		int          errors;

		function new();
			foreach (line_bytes[i]) line_bytes[i] = 8'h00;
			fill = 0;
			scan_pos = 0;
			ovf = 1'b0;
			done = 1'b0;
			errors = 0;
		endfunction

		function void push(logic [7:0] ch, logic found, logic lst);
			result_t r;
			r.token_char    = ch;
			r.token_found   = found;
			r.last          = lst;
			r.overflow_line = done && ovf;
			pending_results.push_back(r);
		endfunction

		// Model one accepted request and queue the token bytes it produces.
		function void note_request(logic [1:0] cmd, logic [7:0] ch);
			int unsigned lft, rgt, stop, p;
			int n;
			result_t r;
			case (cmd)
				CMD_BEGIN: begin
					if (done) begin
						ovf = 1'b0;
						done = 1'b0;
						fill = 0;
						scan_pos = 0;
					end
				end
				CMD_CHAR: begin
					if (!ovf) begin
						if (fill < BUF_DEPTH - 1) begin
							line_bytes[fill] = ch;
							fill++;
						end else begin
							ovf = 1'b1;
							fill = 0;
						end
					end
					if (ch == NL_BYTE) begin
						if (fill < BUF_DEPTH) line_bytes[fill] = 8'h00;
						done = 1'b1;
					end
				end
				CMD_TOKEN: begin
					if (!done) begin
						push(8'h00, 1'b0, 1'b1);
					end else begin
						lft = (scan_pos >= fill) ? fill : scan_pos;
						while (lft < fill && line_bytes[lft] == SP_BYTE) lft++;
						rgt = lft;
						while (rgt < fill) begin
							if (line_bytes[rgt] == SP_BYTE || line_bytes[rgt] == NL_BYTE) begin
								line_bytes[rgt] = 8'h00;
								break;
							end
							rgt++;
						end
						stop = rgt;
						rgt++;
						scan_pos = rgt;
						if (lft == fill || lft + 1 == rgt) begin
							push(8'h00, 1'b0, 1'b1);
						end else begin
							n = 0;
							for (p = lft; p < stop && p < BUF_DEPTH && line_bytes[p] != 8'h00;
								p++) begin
								push(line_bytes[p], 1'b1, 1'b0);
								n++;
							end
							if (n == 0) begin
								push(8'h00, 1'b1, 1'b1);
							end else begin
								r = pending_results.pop_back();
								r.last = 1'b1;
								pending_results.push_back(r);
							end
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void check_result(result_t got);
			result_t exp;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result with nothing pending: char %h found %b last %b ovf %b",
					$time, got.token_char, got.token_found, got.last, got.overflow_line);
				return;
			end
			exp = pending_results.pop_front();
			if (got.token_char !== exp.token_char || got.token_found !== exp.token_found ||
				got.last !== exp.last || got.overflow_line !== exp.overflow_line) begin
				errors++;
				$display({"%0t: token mismatch: expected char %h found %b last %b ovf %b,",
					" got char %h found %b last %b ovf %b"},
					$time, exp.token_char, exp.token_found, exp.last, exp.overflow_line,
					got.token_char, got.token_found, got.last, got.overflow_line);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	lbt_in_if  in_ch();
	lbt_out_if out_ch();

	line_buffer_tokenizer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	lbt_scoreboard sb = new();

	bit steady;
	int hold_cycles;
	int sink_gap;
	int request_count;
	int cycle_count;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(15, 40);
	endfunction

	function automatic logic [7:0] pick_char(bit wordy);
		int r;
		r = $urandom_range(0, 99);
		if (wordy) return (r < 85) ? 8'(8'h61 + $urandom_range(0, 25)) : SP_BYTE;
		if (r < 50) return 8'(8'h61 + $urandom_range(0, 25));
		if (r < 78) return SP_BYTE;
		if (r < 82) return NL_BYTE;
		if (r < 88) return 8'h00;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_request(input logic [1:0] cmd, input logic [7:0] ch);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.command <= cmd;
		in_ch.rx_char <= ch;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sb.note_request(cmd, ch);
		if (cmd != CMD_UNUSED) request_count++;
	endtask

	// stop offering and wait until every expected result has come
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic run_command_line(input bit stress);
		int len, ntok, kind;
		send_request(CMD_BEGIN, 8'($urandom_range(0, 255)));
		kind = $urandom_range(0, 9);
		if (stress) len = $urandom_range(20, 30);
		else if (kind < 7) len = $urandom_range(0, 16);
		else if (kind < 9) len = $urandom_range(28, 34);
		else len = $urandom_range(0, 40);
		repeat (len) send_request(CMD_CHAR, pick_char(stress));
		if (stress || $urandom_range(0, 9) != 0) send_request(CMD_CHAR, NL_BYTE);
		ntok = stress ? 6 : $urandom_range(1, 8);
		repeat (ntok) send_request(CMD_TOKEN, 8'($urandom_range(0, 255)));
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 4)) send_request(CMD_CHAR, pick_char(1'b0));
			repeat ($urandom_range(1, 3)) send_request(CMD_TOKEN, 8'h00);
		end
	endtask

	task automatic run_noise();
		repeat ($urandom_range(1, 6))
			send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
		$display("line_buffer_tokenizer_top verification failed");
		$finish;
	end

	// result side: random backpressure, plus a long hold-off when requested
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				sb.check_result(result_t'{out_ch.token_char, out_ch.token_found,
					out_ch.last, out_ch.overflow_line});
			if (!arst_n) begin
				out_ch.ready <= 1'b0;
			end else if (hold_cycles > 0) begin
				hold_cycles--;
				out_ch.ready <= 1'b0;
			end else if (steady) begin
				out_ch.ready <= 1'b1;
			end else if (sink_gap > 0) begin
				sink_gap--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) sink_gap = pick_gap();
			end
		end
	end

	initial begin
		int line_no;
		steady = 1'b0;
		hold_cycles = 0;
		sink_gap = 0;
		request_count = 0;
		cycle_count = 0;
		arst_n        <= 1'b0;
		in_ch.valid   <= 1'b0;
		in_ch.command <= CMD_BEGIN;
		in_ch.rx_char <= 8'h00;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// token before the line is complete, unused command, begin with no line
		send_request(CMD_TOKEN, 8'hFF);
		send_request(CMD_UNUSED, 8'hFF);
		send_request(CMD_BEGIN, 8'h00);
		// "a<0>b <0>c <FF><NL>": zero inside a token, token led by zero, 0xFF byte
		send_request(CMD_CHAR, 8'h61);
		send_request(CMD_CHAR, 8'h00);
		send_request(CMD_CHAR, 8'h62);
		send_request(CMD_CHAR, SP_BYTE);
		send_request(CMD_CHAR, 8'h00);
		send_request(CMD_CHAR, 8'h63);
		send_request(CMD_CHAR, SP_BYTE);
		send_request(CMD_CHAR, 8'hFF);
		send_request(CMD_CHAR, NL_BYTE);
		repeat (4) send_request(CMD_TOKEN, 8'h00);
		// bytes appended after the newline, last token unterminated
		send_request(CMD_CHAR, 8'h78);
		send_request(CMD_CHAR, 8'h79);
		repeat (2) send_request(CMD_TOKEN, 8'h00);
		send_request(CMD_BEGIN, 8'h00);
		wait_drained();

		line_no = 0;
		while (request_count < RANDOM_REQUESTS) begin
			steady = ($urandom_range(0, 6) == 0);
			if (line_no == 3) begin
				hold_cycles = 300;
				run_command_line(1'b1);
			end else if ($urandom_range(0, 4) == 0) begin
				run_noise();
			end else begin
				run_command_line(1'b0);
			end
			if (line_no % 8 == 7) wait_drained();
			line_no++;
		end

		wait_drained();
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending_results.size() == 0) begin
			$display("line_buffer_tokenizer_top verification clean");
		end else begin
			$display("line_buffer_tokenizer_top verification failed");
		end
		$finish;
	end
endmodule

[filelist.f]
hdl/lbt_pkg.sv
hdl/lbt_ifs.sv
hdl/lbt_ram.sv
hdl/lbt_front.sv
hdl/lbt_back.sv
hdl/line_buffer_tokenizer_top.sv
test/tb.sv
